@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ design/rar_pkg.sv @@
package rar_pkg;
  localparam int OPERAND_WIDTH = 16;
  localparam int NUM_W = 2 * OPERAND_WIDTH + 1;
  localparam int DEN_W = 2 * OPERAND_WIDTH;
  localparam int MAG_W = 2 * OPERAND_WIDTH;
  localparam int IN_W  = 4 * OPERAND_WIDTH;
  localparam int OUT_W = ((NUM_W + DEN_W + 7) / 8) * 8;
  localparam int CNT_W = $clog2(MAG_W + 1);

  typedef struct packed {
    logic [NUM_W-1:0] n;
    logic [DEN_W-1:0] d;
    logic             unit;
  } item_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [MAG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quo;
    logic [MAG_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic push;
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [MAG_W-1:0] mag_num(input logic [NUM_W-1:0] v);
    logic [NUM_W-1:0] t;
    t = v[NUM_W-1] ? (~v + NUM_W'(1)) : v;
    return t[MAG_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] mag_den(input logic [DEN_W-1:0] v);
    return v[DEN_W-1] ? (~v + DEN_W'(1)) : v;
  endfunction
endpackage

@@ design/rar_div.sv @@
module rar_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rar_pkg::div_req_t req,
  output rar_pkg::div_rsp_t rsp
);
  import rar_pkg::*;

  logic [MAG_W:0]   rem_r;
  logic [MAG_W-1:0] quo_r;
  logic [MAG_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [MAG_W:0]   shifted;
  logic [MAG_W:0]   trial;

  // one quotient bit a cycle, restoring
  assign shifted = {rem_r[MAG_W-1:0], quo_r[MAG_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MAG_W);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        if (!trial[MAG_W]) begin
          rem_r <= trial;
          quo_r <= {quo_r[MAG_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          quo_r <= {quo_r[MAG_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r[MAG_W-1:0];
endmodule

@@ design/rar_fifo.sv @@
module rar_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rar_pkg::item_t wr_item,
  input  logic           pop,
  output rar_pkg::item_t rd_item,
  output logic           full,
  output logic           empty
);
  import rar_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= wr_item;
        wr_ptr_r        <= ~wr_ptr_r;
      end
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  assign rd_item = mem_r[rd_ptr_r];
  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
endmodule

@@ design/rar_front.sv @@
module rar_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [rar_pkg::IN_W-1:0]    in_tdata,
  input  logic                        q_full,
  output logic                        q_push,
  output rar_pkg::item_t              q_item
);
  import rar_pkg::*;

  localparam int OW = OPERAND_WIDTH;

  logic signed [OW-1:0]  a, b, c, d;
  logic signed [DEN_W-1:0] ad_r, bc_r, bd_r;
  logic                  p_valid_r;

  assign a = in_tdata[OW-1:0];
  assign b = in_tdata[2*OW-1:OW];
  assign c = in_tdata[3*OW-1:2*OW];
  assign d = in_tdata[4*OW-1:3*OW];

  assign q_push    = p_valid_r && !q_full;
  assign in_tready = !p_valid_r || q_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        ad_r      <= a * d;
        bc_r      <= b * c;
        bd_r      <= b * d;
        p_valid_r <= 1'b1;
      end else if (q_push) begin
        p_valid_r <= 1'b0;
      end
    end
  end

  // sum the cross products and mark a unit denominator
  assign q_item.n    = {ad_r[DEN_W-1], ad_r} + {bc_r[DEN_W-1], bc_r};
  assign q_item.d    = bd_r;
  assign q_item.unit = (bd_r == DEN_W'(1));
endmodule

@@ design/rar_back.sv @@
module rar_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  rar_pkg::item_t             q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [rar_pkg::NUM_W-1:0]  sum_num,
  output logic [rar_pkg::DEN_W-1:0]  sum_den,
  output logic                       undef
);
  import rar_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOOP, S_REM, S_QN, S_QD, S_OUT} state_t;

  state_t           state_r;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r;
  logic [MAG_W-1:0] x_r, y_r, qn_r;
  logic             steps_r;
  logic             gneg;
  logic [NUM_W-1:0] sn, sd;
  div_req_t         req;
  div_rsp_t         rsp;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic             undef_r;

  rar_div u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign q_pop = (state_r == S_IDLE) && !q_empty;
  assign gneg  = steps_r ? d_r[DEN_W-1] : n_r[NUM_W-1];
  assign sn    = (n_r[NUM_W-1] ^ gneg) ? -{1'b0, qn_r} : {1'b0, qn_r};
  assign sd    = (d_r[DEN_W-1] ^ gneg) ? -{1'b0, rsp.quo} : {1'b0, rsp.quo};

  // issue a division in the cycle the state moves on
  always_comb begin
    req = '0;
    case (state_r)
      S_LOOP: begin
        if (y_r != '0) begin
          req = '{start: 1'b1, dividend: x_r, divisor: y_r};
        end else if (x_r != '0) begin
          req = '{start: 1'b1, dividend: mag_num(n_r), divisor: x_r};
        end
      end
      S_QN: begin
        if (rsp.done) begin
          req = '{start: 1'b1, dividend: mag_den(d_r), divisor: x_r};
        end
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (!q_empty) begin
          n_r     <= q_item.n;
          d_r     <= q_item.d;
          x_r     <= mag_num(q_item.n);
          y_r     <= mag_den(q_item.d);
          steps_r <= 1'b0;
          if (q_item.unit) begin
            num_r   <= q_item.n;
            den_r   <= DEN_W'(1);
            undef_r <= 1'b0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (y_r == '0) begin
            // x holds the gcd magnitude
            if (x_r == '0) begin
              num_r   <= '0;
              den_r   <= '0;
              undef_r <= 1'b1;
              state_r <= S_OUT;
            end else begin
              state_r <= S_QN;
            end
          end else begin
            state_r <= S_REM;
          end
        end
        S_REM: if (rsp.done) begin
          x_r     <= y_r;
          y_r     <= rsp.rem;
          steps_r <= ~steps_r;
          state_r <= S_LOOP;
        end
        S_QN: if (rsp.done) begin
          qn_r    <= rsp.quo;
          state_r <= S_QD;
        end
        S_QD: if (rsp.done) begin
          num_r   <= sn;
          den_r   <= sd[DEN_W-1:0];
          undef_r <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = (state_r == S_OUT);
  assign sum_num    = num_r;
  assign sum_den    = den_r;
  assign undef      = undef_r;
endmodule

@@ design/rational_add_reduce_core.sv @@
// Channel | Direction | Contents
// in_     | slave     | num_a, den_a, num_b, den_b (signed fractions to add)
// out_    | master    | sum_num, sum_den (reduced sum), undefined_flag in tuser
//
// Flow: a word passes the front, then one division per Euclid remainder step
//   and two for the final quotients, all on one shared 1-bit-a-cycle divider;
//   a unit denominator skips the divider.
// Reset: rst_n synchronous, active low; clears the pipeline and queue controls.
// Stalls: a two-entry queue parts the product front from the gcd back; while a result
//   waits in the output register, the front takes words until it and the queue are full.
`include "assert_macros.svh"
module rational_add_reduce_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // num_a[15:0], den_a[31:16], num_b[47:32], den_b[63:48]
  input  logic [rar_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // sum_num[32:0], sum_den[64:33], zero fill above
  output logic [rar_pkg::OUT_W-1:0]  out_tdata,
  // undefined_flag[0]
  output logic                       out_tuser
);
  import rar_pkg::*;

  item_t            f_item, b_item;
  q_stat_t          qs;
  logic             q_pop;
  logic [NUM_W-1:0] sum_num;
  logic [DEN_W-1:0] sum_den;

  // front: cross-multiply and classify
  rar_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_full(qs.full), .q_push(qs.push), .q_item(f_item)
  );

  // queue between front and back
  rar_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(qs.push), .wr_item(f_item), .pop(q_pop), .rd_item(b_item),
    .full(qs.full), .empty(qs.empty)
  );

  // back: gcd and reduction
  rar_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(qs.empty), .q_item(b_item), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sum_num(sum_num), .sum_den(sum_den), .undef(out_tuser)
  );

  assign out_tdata = {(OUT_W - NUM_W - DEN_W)'(0), sum_den, sum_num};

  `ASSERT_CLK(a_no_overflow, !(qs.push && qs.full), "queue pushed while full")
  `ASSERT_CLK(a_no_underflow, !(q_pop && qs.empty), "queue popped while empty")
  `ASSERT_CLK(a_undef_zero, (out_tvalid && out_tuser) |-> (out_tdata == '0), "undefined nonzero")
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import rar_pkg::*;

  localparam int W = OPERAND_WIDTH;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             undef;
  } sum_t;

  typedef struct {
    logic [W-1:0] na, da, nb, db;
    bit           known;  // expected sum typed in below
    sum_t         sum;
  } vec_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;

  sum_t pending_sums[$];
  int   err_cnt;
  bit   stim_done;
  bit   hold_off;   // long receiver stall request

  rational_add_reduce_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Add two fractions and reduce by the signed Euclid gcd.
  function automatic sum_t reduce_sum(logic [W-1:0] na, logic [W-1:0] da,
                                      logic [W-1:0] nb, logic [W-1:0] db);
    longint a, b, c, d;
    logic [63:0] n, dd, x, y, r, g;
    int steps;
    bit gneg, nneg, dneg;
    sum_t s;
    a = longint'($signed(na));
    b = longint'($signed(da));
    c = longint'($signed(nb));
    d = longint'($signed(db));
    n = a * d + b * c;
    dd = b * d;
    s.undef = 1'b0;
    if (dd == 64'd1) begin
      s.num = n[NUM_W-1:0];
      s.den = DEN_W'(1);
      return s;
    end
    nneg = n[63];
    dneg = dd[63];
    x = nneg ? -n : n;
    y = dneg ? -dd : dd;
    steps = 0;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
      steps++;
    end
    g = x;
    if (g == 0) begin
      s.num = '0;
      s.den = '0;
      s.undef = 1'b1;
      return s;
    end
    gneg = steps[0] ? dneg : nneg;
    x = (nneg ? -n : n) / g;
    y = (dneg ? -dd : dd) / g;
    if (nneg != gneg) x = -x;
    if (dneg != gneg) y = -y;
    s.num = x[NUM_W-1:0];
    s.den = y[DEN_W-1:0];
    return s;
  endfunction

  // Queue one word and wait until the block takes it.
  task automatic send_word(vec_t v);
    sum_t s;
    s = reduce_sum(v.na, v.da, v.nb, v.db);
    if (v.known && (s != v.sum)) begin
      $display("%0t: table row disagrees with predictor exp %h/%h/%b got %h/%h/%b",
               $time, v.sum.num, v.sum.den, v.sum.undef, s.num, s.den, s.undef);
      err_cnt++;
    end
    pending_sums.push_back(v.known ? v.sum : s);
    in_tdata  <= {v.db, v.nb, v.da, v.na};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_sender(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [W-1:0] rand_op();
    case ($urandom_range(0, 9))
      0: return {1'b1, {(W-1){1'b0}}};
      1: return {1'b0, {(W-1){1'b1}}};
      2: return '0;
      3: return W'(1);
      4: return '1;
      5, 6: return W'($signed($urandom_range(0, 40)) - 20);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic vec_t mk(int na, int da, int nb, int db);
    vec_t v;
    v.na = W'(na); v.da = W'(da); v.nb = W'(nb); v.db = W'(db);
    v.known = 1'b0;
    v.sum = '{default: '0};
    return v;
  endfunction

  function automatic vec_t mk_exp(int na, int da, int nb, int db,
                                  longint sn, longint sd, bit u);
    vec_t v;
    v = mk(na, da, nb, db);
    v.known = 1'b1;
    v.sum.num = NUM_W'(sn);
    v.sum.den = DEN_W'(sd);
    v.sum.undef = u;
    return v;
  endfunction

  // Stimulus: directed table, then bursts of random words.
  initial begin
    vec_t dir_tab[$];
    vec_t v;
    int burst;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rst_n     = 1'b0;
    err_cnt   = 0;
    stim_done = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unit denominator, even with a zero sum.
    dir_tab.push_back(mk_exp(0, 1, 0, 1, 0, 1, 0));
    dir_tab.push_back(mk_exp(3, 1, 4, 1, 7, 1, 0));
    dir_tab.push_back(mk_exp(5, -1, 2, -1, -7, 1, 0));
    // Zero gcd flags undefined.
    dir_tab.push_back(mk_exp(0, 0, 0, 0, 0, 0, 1));
    dir_tab.push_back(mk_exp(7, 0, 0, 0, 0, 0, 1));
    // Zero denominator, nonzero numerator gives 1/0.
    dir_tab.push_back(mk_exp(3, 0, 0, 5, 1, 0, 0));
    // Zero numerator gives 0/1; 1/2 + 1/2 gives 1/1.
    dir_tab.push_back(mk_exp(0, 3, 0, 5, 0, 1, 0));
    dir_tab.push_back(mk_exp(1, 2, 1, 2, 1, 1, 0));
    // Extremes and negative gcd cases go through the predictor.
    dir_tab.push_back(mk(-32768, -32768, -32768, -32768));
    dir_tab.push_back(mk(32767, 32767, 32767, 32767));
    dir_tab.push_back(mk(-32768, 32767, 32767, -32768));
    dir_tab.push_back(mk(32767, -32768, -32768, 1));
    dir_tab.push_back(mk(-1, -1, -1, -1));
    dir_tab.push_back(mk(1, -3, 1, 6));
    dir_tab.push_back(mk(-5, 7, 3, -11));
    dir_tab.push_back(mk(12345, -32768, -1, 2));
    dir_tab.push_back(mk(21845, -21846, -21846, 21845));
    dir_tab.push_back(mk(1, 32767, -1, -32768));
    foreach (dir_tab[i]) send_word(dir_tab[i]);
    idle_sender(1);

    // Pause until all results are back.
    wait (pending_sums.size() == 0);
    @(posedge clk);

    for (int i = 0; i < 450; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && i < 450; k++, i++) begin
        v = mk(0, 0, 0, 0);
        v.na = rand_op(); v.da = rand_op();
        v.nb = rand_op(); v.db = rand_op();
        send_word(v);
        // Long receiver stall while the sender keeps going.
        if (i == 120) hold_off <= 1'b1;
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 150));
    end
    in_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Receiver: random stalls, runs of full readiness, one long hold-off.
  initial begin
    int mode;
    out_tready = 1'b0;
    hold_off   = 1'b0;
    mode       = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off <= 1'b0;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    sum_t exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result %h user %b", $time, out_tdata, out_tuser);
        err_cnt++;
      end else begin
        exp_s = pending_sums.pop_front();
        if (out_tdata[NUM_W-1:0] !== exp_s.num) begin
          $display("%0t: sum_num exp %h got %h", $time, exp_s.num,
                   out_tdata[NUM_W-1:0]);
          err_cnt++;
        end
        if (out_tdata[NUM_W+DEN_W-1:NUM_W] !== exp_s.den) begin
          $display("%0t: sum_den exp %h got %h", $time, exp_s.den,
                   out_tdata[NUM_W+DEN_W-1:NUM_W]);
          err_cnt++;
        end
        if (out_tuser !== exp_s.undef) begin
          $display("%0t: undefined_flag exp %b got %b", $time, exp_s.undef, out_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Drain, settle, report.
  initial begin
    wait (stim_done);
    wait (pending_sums.size() == 0);
    repeat (200) @(posedge clk);
    if (pending_sums.size() == 0 && err_cnt == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Worst case: ~470 words plus receiver stalls; stop with errors if still running here.
  initial begin
    #40_000_000;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/rar_pkg.sv
design/rar_div.sv
design/rar_fifo.sv
design/rar_front.sv
design/rar_back.sv
design/rational_add_reduce_core.sv
tb/sv/tb_top.sv
